// ===== rtl/bmpb_pkg.sv =====
package bmpb_pkg;

   localparam int PIXEL_BYTE_WIDTH  = 8;
   localparam int IMG_DIM_WIDTH     = 12;
   localparam int OFFSET_WIDTH      = 13;
   localparam int SCREEN_POS_WIDTH  = 14;
   localparam int ADDRESS_WIDTH     = 19;
   localparam int COLOR_WIDTH       = 24;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 13;
   localparam int REQ_TDATA_WIDTH   = 8;
   localparam int RSP_TDATA_WIDTH   = 48;

   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;
   localparam logic [1:0] PHASE_PAD   = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_OFFSET     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_OFFSET     = 2'd3;

   typedef struct packed {
      logic        [IMG_DIM_WIDTH-1:0] image_width;
      logic        [IMG_DIM_WIDTH-1:0] image_height;
      logic signed [OFFSET_WIDTH-1:0]  x_offset;
      logic signed [OFFSET_WIDTH-1:0]  y_offset;
   } cfg_type;

   typedef struct packed {
      logic signed [SCREEN_POS_WIDTH-1:0] screen_x;
      logic signed [SCREEN_POS_WIDTH-1:0] screen_y;
      logic        [COLOR_WIDTH-1:0]      color;
   } pixel_type;

endpackage

// ===== rtl/bmp_bgr_to_framebuffer_blit.sv =====
// channel  direction  tdata / data                      handshake
// req      in         pixel_byte[7:0]                   req_tvalid / req_tready
// rsp      out        pixel_address, pixel_color        rsp_tvalid / rsp_tready
// csr      in         csr_index, csr_wdata              csr_wr_en
//
// One byte per cycle while req_tready is high; a write is registered in unpack, then in place.
// Rate is set by the byte sequencer: one counter update per byte.
// Reset is synchronous and clears the byte phase, counters and both valid stages.
// A stalled rsp side holds its result; req_tready stays high while the pixel stage can advance.
module bmp_bgr_to_framebuffer_blit #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [bmpb_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,  // [7:0] pixel_byte
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [bmpb_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,  // [18:0] pixel_address,
                                                               // [42:19] pixel_color
   input  logic                                    csr_wr_en,
   input  logic [bmpb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bmpb_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import bmpb_pkg::*;

   cfg_type                  cfg_ff, cfg_in;
   logic                     pix_valid;
   logic                     pix_ready;
   pixel_type                pix;
   logic [ADDRESS_WIDTH-1:0] pixel_address;
   logic [COLOR_WIDTH-1:0]   pixel_color;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[IMG_DIM_WIDTH-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[IMG_DIM_WIDTH-1:0];
            CSR_X_OFFSET:     cfg_in.x_offset     = $signed(csr_wdata);
            CSR_Y_OFFSET:     cfg_in.y_offset     = $signed(csr_wdata);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= IMG_DIM_WIDTH'(1);
         cfg_ff.image_height <= IMG_DIM_WIDTH'(1);
         cfg_ff.x_offset     <= '0;
         cfg_ff.y_offset     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmpb_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .pixel_byte (req_tdata[PIXEL_BYTE_WIDTH-1:0]),
      .pix_valid  (pix_valid),
      .pix_ready  (pix_ready),
      .pix        (pix)
   );

   bmpb_place #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_place (
      .clock         (clock),
      .reset         (reset),
      .pix_valid     (pix_valid),
      .pix_ready     (pix_ready),
      .pix           (pix),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .pixel_address (pixel_address),
      .pixel_color   (pixel_color)
   );

   assign rsp_tdata = {{(RSP_TDATA_WIDTH-ADDRESS_WIDTH-COLOR_WIDTH){1'b0}},
                       pixel_color, pixel_address};

endmodule

// ===== rtl/bmpb_unpack.sv =====
module bmpb_unpack (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bmpb_pkg::cfg_type                      cfg,
   input  logic                                   byte_valid,
   output logic                                   byte_ready,
   input  logic [bmpb_pkg::PIXEL_BYTE_WIDTH-1:0]  pixel_byte,
   output logic                                   pix_valid,
   input  logic                                   pix_ready,
   output bmpb_pkg::pixel_type                    pix
);
   import bmpb_pkg::*;

   logic [1:0]               phase_ff, phase_in;
   logic [15:0]              hold_ff, hold_in;
   logic [IMG_DIM_WIDTH-1:0] column_ff, column_in;
   logic [IMG_DIM_WIDTH-1:0] row_ff, row_in;
   logic [1:0]               pad_ff, pad_in;
   logic                     pix_valid_ff, pix_valid_in;
   pixel_type                pix_ff, pix_in;

   logic                     accept;
   logic [IMG_DIM_WIDTH-1:0] eff_width;
   logic [IMG_DIM_WIDTH-1:0] eff_height;
   logic [1:0]               pad_len;
   logic [IMG_DIM_WIDTH:0]   column_next;
   logic [IMG_DIM_WIDTH:0]   row_next;
   logic [2:0]               pad_next;
   logic [IMG_DIM_WIDTH-1:0] height_m1;

   assign accept      = byte_valid && byte_ready;
   assign byte_ready  = !pix_valid_ff || pix_ready;
   assign eff_width   = (cfg.image_width == '0) ? IMG_DIM_WIDTH'(1) : cfg.image_width;
   assign eff_height  = (cfg.image_height == '0) ? IMG_DIM_WIDTH'(1) : cfg.image_height;
   assign height_m1   = eff_height - IMG_DIM_WIDTH'(1);
   assign pad_len     = eff_width[1:0];
   assign column_next = {1'b0, column_ff} + (IMG_DIM_WIDTH+1)'(1);
   assign row_next    = {1'b0, row_ff} + (IMG_DIM_WIDTH+1)'(1);
   assign pad_next    = {1'b0, pad_ff} + 3'd1;

   always_comb begin
      logic end_row;
      end_row      = 1'b0;
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      pad_in       = pad_ff;
      pix_valid_in = pix_valid_ff && !pix_ready;
      pix_in       = pix_ff;
      if (accept) begin
         pix_valid_in = 1'b0;
         unique case (phase_ff)
            PHASE_BLUE: begin
               hold_in  = {hold_ff[15:8], pixel_byte};
               phase_in = PHASE_GREEN;
            end
            PHASE_GREEN: begin
               hold_in  = {pixel_byte, hold_ff[7:0]};
               phase_in = PHASE_RED;
            end
            PHASE_RED: begin
               pix_valid_in    = 1'b1;
               pix_in.screen_x = SCREEN_POS_WIDTH'(cfg.x_offset)
                               + $signed({2'b00, column_ff});
               pix_in.screen_y = SCREEN_POS_WIDTH'(cfg.y_offset)
                               + $signed({2'b00, height_m1})
                               - $signed({2'b00, row_ff});
               pix_in.color    = {pixel_byte, hold_ff};
               if (column_next >= {1'b0, eff_width}) begin
                  if (pad_len != 2'd0) begin
                     phase_in = PHASE_PAD;
                     pad_in   = 2'd0;
                  end else begin
                     end_row = 1'b1;
                  end
               end else begin
                  column_in = column_next[IMG_DIM_WIDTH-1:0];
                  phase_in  = PHASE_BLUE;
               end
            end
            PHASE_PAD: begin
               if (pad_next >= {1'b0, pad_len}) begin
                  end_row = 1'b1;
               end else begin
                  pad_in = pad_next[1:0];
               end
            end
            default: begin
               phase_in = PHASE_BLUE;
            end
         endcase
         if (end_row) begin
            column_in = '0;
            pad_in    = 2'd0;
            phase_in  = PHASE_BLUE;
            row_in    = (row_next >= {1'b0, eff_height}) ? '0
                                                         : row_next[IMG_DIM_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_BLUE;
         hold_ff      <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         pad_ff       <= '0;
         pix_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         pad_ff       <= pad_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

endmodule

// ===== rtl/bmpb_place.sv =====
module bmpb_place #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pix_valid,
   output logic                                  pix_ready,
   input  bmpb_pkg::pixel_type                   pix,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [bmpb_pkg::ADDRESS_WIDTH-1:0]    pixel_address,
   output logic [bmpb_pkg::COLOR_WIDTH-1:0]      pixel_color
);
   import bmpb_pkg::*;

   localparam int PROD_WIDTH = 2 * IMG_DIM_WIDTH + 1;

   logic                     valid_ff, valid_in;
   logic [ADDRESS_WIDTH-1:0] address_ff, address_in;
   logic [COLOR_WIDTH-1:0]   color_ff, color_in;
   logic                     on_screen;
   logic [PROD_WIDTH-1:0]    row_base;
   logic [PROD_WIDTH-1:0]    linear;

   assign pix_ready = !valid_ff || out_ready;

   assign on_screen = (pix.screen_x >= 0)
                   && (pix.screen_x < $signed(SCREEN_POS_WIDTH'(SCREEN_WIDTH)))
                   && (pix.screen_y >= 0)
                   && (pix.screen_y < $signed(SCREEN_POS_WIDTH'(SCREEN_HEIGHT)));

   assign row_base = PROD_WIDTH'(pix.screen_y[IMG_DIM_WIDTH-1:0])
                   * PROD_WIDTH'(SCREEN_WIDTH);
   assign linear   = row_base + PROD_WIDTH'(pix.screen_x[IMG_DIM_WIDTH-1:0]);

   always_comb begin
      valid_in   = valid_ff && !out_ready;
      address_in = address_ff;
      color_in   = color_ff;
      if (pix_valid && pix_ready) begin
         valid_in   = on_screen;
         address_in = linear[ADDRESS_WIDTH-1:0];
         color_in   = pix.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      color_ff   <= color_in;
   end

   assign out_valid     = valid_ff;
   assign pixel_address = address_ff;
   assign pixel_color   = color_ff;

endmodule

// ===== verif/blit_write_checker.sv =====
module blit_write_checker #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   input  logic [bmpb_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,  // [7:0] pixel_byte
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [bmpb_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,  // [18:0] pixel_address,
                                                               // [42:19] pixel_color
   input  logic                                    csr_wr_en,
   input  logic [bmpb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bmpb_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   output int                                      mismatch_count,
   output int                                      writes_pending
);
   import bmpb_pkg::*;

   typedef struct packed {
      logic [ADDRESS_WIDTH-1:0] address;
      logic [COLOR_WIDTH-1:0]   color;
   } fb_write_type;

   fb_write_type               expected_writes [$];
   cfg_type                    geometry;
   logic [1:0]                 byte_phase;
   logic [15:0]                blue_green;
   logic [IMG_DIM_WIDTH-1:0]   column;
   logic [IMG_DIM_WIDTH-1:0]   row;
   logic [1:0]                 pads_seen;

   task automatic close_row(input int eff_height);
      column     = '0;
      pads_seen  = '0;
      byte_phase = PHASE_BLUE;
      if (int'(row) + 1 >= eff_height) begin
         row = '0;
      end else begin
         row = row + 1'b1;
      end
   endtask

   task automatic place_pixel_byte(input logic [7:0] value);
      int           eff_width;
      int           eff_height;
      int           pad_bytes;
      int           screen_x;
      int           screen_y;
      fb_write_type write;
      eff_width  = (geometry.image_width == '0) ? 1 : int'(geometry.image_width);
      eff_height = (geometry.image_height == '0) ? 1 : int'(geometry.image_height);
      pad_bytes  = eff_width % 4;
      case (byte_phase)
         PHASE_BLUE: begin
            blue_green = {8'h00, value};
            byte_phase = PHASE_GREEN;
         end
         PHASE_GREEN: begin
            blue_green = {value, blue_green[7:0]};
            byte_phase = PHASE_RED;
         end
         PHASE_RED: begin
            screen_x = int'($signed(geometry.x_offset)) + int'(column);
            screen_y = int'($signed(geometry.y_offset)) + eff_height - 1 - int'(row);
            if (screen_x >= 0 && screen_x < SCREEN_WIDTH &&
                screen_y >= 0 && screen_y < SCREEN_HEIGHT) begin
               write.address = ADDRESS_WIDTH'(screen_x + screen_y * SCREEN_WIDTH);
               write.color   = {value, blue_green};
               expected_writes.push_back(write);
            end
            if (int'(column) + 1 >= eff_width) begin
               if (pad_bytes != 0) begin
                  byte_phase = PHASE_PAD;
                  pads_seen  = '0;
               end else begin
                  close_row(eff_height);
               end
            end else begin
               column     = column + 1'b1;
               byte_phase = PHASE_BLUE;
            end
         end
         default: begin
            if (int'(pads_seen) + 1 >= pad_bytes) begin
               close_row(eff_height);
            end else begin
               pads_seen = pads_seen + 1'b1;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      fb_write_type oldest;
      if (reset) begin
         geometry.image_width  = IMG_DIM_WIDTH'(1);
         geometry.image_height = IMG_DIM_WIDTH'(1);
         geometry.x_offset     = '0;
         geometry.y_offset     = '0;
         byte_phase            = PHASE_BLUE;
         blue_green            = '0;
         column                = '0;
         row                   = '0;
         pads_seen             = '0;
         mismatch_count        = 0;
         expected_writes.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            place_pixel_byte(req_tdata[7:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected pixel write, address %0d color %h", $time,
                        rsp_tdata[18:0], rsp_tdata[42:19]);
               mismatch_count++;
            end else begin
               oldest = expected_writes.pop_front();
               if (rsp_tdata[18:0] !== oldest.address) begin
                  $display("%0t: pixel_address expected %0d, got %0d", $time,
                           oldest.address, rsp_tdata[18:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[42:19] !== oldest.color) begin
                  $display("%0t: pixel_color expected %h, got %h", $time,
                           oldest.color, rsp_tdata[42:19]);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  geometry.image_width  = csr_wdata[IMG_DIM_WIDTH-1:0];
               CSR_IMAGE_HEIGHT: geometry.image_height = csr_wdata[IMG_DIM_WIDTH-1:0];
               CSR_X_OFFSET:     geometry.x_offset     = csr_wdata;
               CSR_Y_OFFSET:     geometry.y_offset     = csr_wdata;
            endcase
         end
      end
      writes_pending = expected_writes.size();
   end

endmodule

// ===== verif/bmp_bgr_to_framebuffer_blit_tb.sv =====
module bmp_bgr_to_framebuffer_blit_tb;
   import bmpb_pkg::*;

   localparam int SCREEN_WIDTH  = 800;
   localparam int SCREEN_HEIGHT = 480;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_BYTES  = 1500;
   localparam int SETTLE_CYCLES = 8;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [REQ_TDATA_WIDTH-1:0]   req_tdata;   // [7:0] pixel_byte
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata;   // [18:0] pixel_address, [42:19] pixel_color
   logic                         csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [CSR_DATA_WIDTH-1:0]    csr_wdata;

   int mismatch_count;
   int writes_pending;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int send_idle_by_phase  [4] = '{0, 49, 0, 12};
   int recv_stall_by_phase [4] = '{0, 0, 49, 12};

   bmp_bgr_to_framebuffer_blit #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   blit_write_checker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .writes_pending (writes_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bmp_bgr_to_framebuffer_blit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_request(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drop valid, drain outstanding writes, then cover the pipeline latency
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (writes_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_geometry(input int width, input int height,
                                input int x_off, input int y_off);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_WIDTH'(width);
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_WIDTH'(height);
      @(negedge clock);
      csr_index <= CSR_X_OFFSET;
      csr_wdata <= CSR_DATA_WIDTH'(x_off);
      @(negedge clock);
      csr_index <= CSR_Y_OFFSET;
      csr_wdata <= CSR_DATA_WIDTH'(y_off);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_dimension();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 0;
      if (r == 1) return 4095;
      if (r < 17) return $urandom_range(1, 8);
      return $urandom_range(1, 4095);
   endfunction

   function automatic int pick_offset(input int span);
      int r;
      r = $urandom_range(19);
      if (r == 0) return -4096;
      if (r == 1) return 4095;
      if (r == 2) return int'($urandom_range(8191)) - 4096;
      return int'($urandom_range(span + 16)) - 16;
   endfunction

   initial begin
      int random_bytes;
      int segment;
      int chunk;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_IMAGE_WIDTH;
      csr_wdata  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset geometry: one pixel plus one pad byte at the screen origin
      push_request(8'h00);
      push_request(8'h00);
      push_request(8'h00);
      push_request(8'hFF);
      settle_block();
      // zero size acts as one pixel; land on the last screen address
      load_geometry(0, 0, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
      push_request(8'hFF);
      push_request(8'hFF);
      push_request(8'hFF);
      push_request(8'h00);
      settle_block();
      // 2x2 with padding, clipped on the left and below the screen, then image wrap
      load_geometry(2, 2, -1, SCREEN_HEIGHT - 1);
      for (int k = 0; k < 16; k++) push_request(8'(17 * k));

      random_bytes = 0;
      segment      = 0;
      while (random_bytes < RANDOM_BYTES) begin
         settle_block();
         send_idle_pct  = send_idle_by_phase[segment % 4];
         recv_stall_pct = recv_stall_by_phase[segment % 4];
         if (segment == 0) begin
            load_geometry(4095, 4095, -4096, -4096);
         end else if (segment == 1) begin
            load_geometry(4095, 4095, 0, -3615);
         end else begin
            load_geometry(pick_dimension(), pick_dimension(),
                          pick_offset(SCREEN_WIDTH), pick_offset(SCREEN_HEIGHT));
         end
         chunk = $urandom_range(24, 120);
         repeat (chunk) push_request(8'($urandom_range(255)));
         random_bytes += chunk;
         segment++;
      end
      settle_block();

      if (mismatch_count == 0) begin
         $display("bmp_bgr_to_framebuffer_blit regression: pass");
      end else begin
         $display("bmp_bgr_to_framebuffer_blit regression: fail");
      end
      $finish;
   end

endmodule
